[rtl/gsdt_pkg.sv]
// ----------------------------------------------------------------------------
// gsdt_pkg: shared types and constants of the gyro step distance tracker
// Holds the register indexes, fixed-point constants and the record that
// travels from the front end to the back end.
// ----------------------------------------------------------------------------
package gsdt_pkg;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_REST_LOW   = 2'd0;
  localparam logic [1:0] REG_REST_HIGH  = 2'd1;
  localparam logic [1:0] REG_START_THR  = 2'd2;
  localparam logic [1:0] REG_LEG_LENGTH = 2'd3;

  localparam int unsigned MAX_SAMPLES = 128;

  localparam logic [22:0] ANGLE_K    = 23'd6859714;
  localparam logic [18:0] TWO_PI_Q16 = 19'd411775;
  localparam logic [30:0] ONE_Q30    = 31'h4000_0000;

  // Reset values of the registers.
  localparam logic signed [15:0] REST_LOW_RST  = -16'sd100;
  localparam logic signed [15:0] REST_HIGH_RST = 16'sd100;
  localparam logic signed [15:0] START_THR_RST = 16'sd2000;
  localparam logic [10:0]        LEG_RST       = 11'd920;

  // One classified sample, passed from front end to back end.
  typedef struct packed {
    logic        done;      // this sample closed a step
    logic        in_step;   // step open after this sample
    logic [23:0] mag;       // |rate_sum| at close
    logic [7:0]  count;     // sample_count at close
    logic [15:0] dur;       // step_duration_ms at close
    logic [10:0] leg;       // leg length at close
  } work_t;

  // Back end sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_DIV,
    ST_FOLD,
    ST_USQ,
    ST_HORN_MUL,
    ST_HORN_REC,
    ST_HORN_DIV,
    ST_DIST,
    ST_VSET,
    ST_VDIV,
    ST_OUT
  } state_t;

endpackage

[rtl/gsdt_front.sv]
// ----------------------------------------------------------------------------
// gsdt_front: sample classifier
// Holds the configuration and the open-step accumulators, classifies each
// sample and hands one work record per sample to the queue.
// ----------------------------------------------------------------------------
module gsdt_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_data,
  input  logic                 take,
  input  logic signed [15:0]   rate_sample,
  input  logic [9:0]           elapsed_ms,
  output gsdt_pkg::work_t      work
);

  logic signed [15:0] rest_low, rest_high, start_thr;
  logic [10:0]        leg;
  logic               step_open;
  logic signed [23:0] rate_sum;
  logic [7:0]         sample_count;
  logic [15:0]        dur;

  logic signed [23:0] sum_acc;
  logic [7:0]         cnt_acc;
  logic [16:0]        dur_wide;
  logic [15:0]        dur_acc;
  logic               closes, opens;

  // Accumulate the current sample into the open step.
  always_comb begin
    sum_acc  = rate_sum;
    cnt_acc  = sample_count;
    dur_wide = {1'b0, dur} + {7'd0, elapsed_ms};
    if (sample_count < 8'(gsdt_pkg::MAX_SAMPLES)) begin
      sum_acc = rate_sum + 24'(rate_sample);
      cnt_acc = sample_count + 8'd1;
    end
    dur_acc = dur_wide[16] ? 16'hFFFF : dur_wide[15:0];
    closes  = step_open && (rate_sample > rest_low) && (rate_sample < rest_high);
    opens   = (rate_sample > start_thr) && (closes || !step_open);
  end

  // Work record for the back end.
  always_comb begin
    work.done    = closes;
    work.in_step = opens || (step_open && !closes);
    work.mag     = sum_acc[23] ? 24'(-sum_acc) : sum_acc;
    work.count   = cnt_acc;
    work.dur     = dur_acc;
    work.leg     = leg;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      rest_low  <= gsdt_pkg::REST_LOW_RST;
      rest_high <= gsdt_pkg::REST_HIGH_RST;
      start_thr <= gsdt_pkg::START_THR_RST;
      leg       <= gsdt_pkg::LEG_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        gsdt_pkg::REG_REST_LOW:   rest_low  <= cfg_data;
        gsdt_pkg::REG_REST_HIGH:  rest_high <= cfg_data;
        gsdt_pkg::REG_START_THR:  start_thr <= cfg_data;
        gsdt_pkg::REG_LEG_LENGTH: leg       <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // Step accumulators.
  always_ff @(posedge clk) begin
    if (rst) begin
      step_open    <= 1'b0;
      rate_sum     <= '0;
      sample_count <= '0;
      dur          <= '0;
    end else if (take) begin
      if (opens || closes) begin
        step_open    <= opens;
        rate_sum     <= '0;
        sample_count <= '0;
        dur          <= '0;
      end else if (step_open) begin
        rate_sum     <= sum_acc;
        sample_count <= cnt_acc;
        dur          <= dur_acc;
      end
    end
  end

endmodule

[rtl/gsdt_queue.sv]
// ----------------------------------------------------------------------------
// gsdt_queue: small FIFO of work records
// Four-entry queue that decouples the classifier from the back end.
// ----------------------------------------------------------------------------
module gsdt_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr,
  input  gsdt_pkg::work_t wdata,
  output logic            full,
  input  logic            rd,
  output logic            empty,
  output gsdt_pkg::work_t rdata
);

  gsdt_pkg::work_t mem [4];
  logic [1:0] wp, rp;
  logic [2:0] cnt;

  assign full  = cnt[2];
  assign empty = (cnt == 3'd0);
  assign rdata = mem[rp];

  // Storage, written on every push transfer.
  always_ff @(posedge clk) begin
    if (wr && !full) begin
      mem[wp] <= wdata;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (wr && !full) wp <= wp + 2'd1;
      if (rd && !empty) rp <= rp + 2'd1;
      cnt <= cnt + 3'(wr && !full) - 3'(rd && !empty);
    end
  end

endmodule

[rtl/gsdt_back.sv]
// ----------------------------------------------------------------------------
// gsdt_back: step close engine
// Works out phase, |cos|, step distance and velocity with narrow multipliers,
// a radix-2 divider for the phase and velocity divisions and reciprocal
// multiplication for the Horner constants, and keeps the step and distance
// totals.
// ----------------------------------------------------------------------------
module gsdt_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_empty,
  input  gsdt_pkg::work_t q_data,
  output logic            q_pop,
  output logic            res_valid,
  input  logic            res_pop,
  output logic            step_done,
  output logic [15:0]     step_total,
  output logic [31:0]     distance_mm,
  output logic [20:0]     velocity_mm_s,
  output logic            in_step
);

  gsdt_pkg::state_t state, state_next;
  gsdt_pkg::work_t  w;

  logic [63:0] acc;      // products and dividend
  logic [63:0] quo;      // divider quotient shift register
  logic [31:0] rem;      // divider partial remainder
  logic [31:0] dvsr;
  logic [5:0]  bitn;
  logic [2:0]  hstage;
  logic [31:0] u2;
  logic [30:0] t;
  logic [15:0] steps;
  logic [31:0] dist_total;
  logic [11:0] d;
  logic [30:0] u;
  logic [31:0] hp;       // Horner product before the constant division
  logic [31:0] hq;       // reciprocal estimate of hp / hk

  logic [32:0] rem_sh;
  logic [33:0] sub;
  logic [63:0] qnext;
  logic [47:0] g;
  logic [46:0] gq;
  logic [31:0] h32;
  logic [6:0]  hk;
  logic [31:0] hm;
  logic [5:0]  hs;
  logic [63:0] hprod;
  logic [31:0] hrem;
  logic [31:0] hquo;
  logic [32:0] dsum;

  // Horner divisor per stage with its reciprocal and shift.
  // The estimate (x * hm) >> hs is at most one below x / hk for any 32-bit x.
  always_comb begin
    case (hstage)
      3'd0: begin
        hk = 7'd90; hm = 32'd3054198966; hs = 6'd38;
      end
      3'd1: begin
        hk = 7'd56; hm = 32'd2454267026; hs = 6'd37;
      end
      3'd2: begin
        hk = 7'd30; hm = 32'd2290649224; hs = 6'd36;
      end
      3'd3: begin
        hk = 7'd12; hm = 32'd2863311530; hs = 6'd35;
      end
      default: begin
        hk = 7'd2;  hm = 32'd2147483648; hs = 6'd32;
      end
    endcase
  end

  // Reciprocal product and the one-step quotient fix-up.
  always_comb begin
    hprod = {32'd0, hp} * {32'd0, hm};
    hrem  = hp - ({25'd0, hk} * hq);
    hquo  = (hrem >= {25'd0, hk}) ? hq + 32'd1 : hq;
  end

  // One restoring division step.
  always_comb begin
    rem_sh = {rem, acc[63]};
    sub    = {1'b0, rem_sh} - {2'b0, dvsr};
    qnext  = {quo[62:0], ~sub[33]};
  end

  // Quarter-turn fold of the 48-bit phase.
  always_comb begin
    g    = {1'b0, quo[46:0]};
    gq   = (g > 48'h4000_0000_0000) ? 47'(48'h8000_0000_0000 - g) : g[46:0];
    h32  = {1'b0, gq[46:16]};
    dsum = {1'b0, dist_total} + {21'd0, d};
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      gsdt_pkg::ST_IDLE:
        if (!q_empty) state_next = q_data.done ? gsdt_pkg::ST_MUL1 : gsdt_pkg::ST_OUT;
      gsdt_pkg::ST_MUL1: state_next = gsdt_pkg::ST_MUL2;
      gsdt_pkg::ST_MUL2: state_next = gsdt_pkg::ST_DIV;
      gsdt_pkg::ST_DIV:  if (bitn == 6'd63) state_next = gsdt_pkg::ST_FOLD;
      gsdt_pkg::ST_FOLD: state_next = gsdt_pkg::ST_USQ;
      gsdt_pkg::ST_USQ:  state_next = gsdt_pkg::ST_HORN_MUL;
      gsdt_pkg::ST_HORN_MUL: state_next = gsdt_pkg::ST_HORN_REC;
      gsdt_pkg::ST_HORN_REC: state_next = gsdt_pkg::ST_HORN_DIV;
      gsdt_pkg::ST_HORN_DIV:
        state_next = (hstage == 3'd4) ? gsdt_pkg::ST_DIST : gsdt_pkg::ST_HORN_MUL;
      gsdt_pkg::ST_DIST: state_next = gsdt_pkg::ST_VSET;
      gsdt_pkg::ST_VSET: state_next = gsdt_pkg::ST_VDIV;
      gsdt_pkg::ST_VDIV: if (bitn == 6'd63) state_next = gsdt_pkg::ST_OUT;
      gsdt_pkg::ST_OUT:  if (res_pop) state_next = gsdt_pkg::ST_IDLE;
      default: state_next = gsdt_pkg::ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    q_pop     = (state == gsdt_pkg::ST_IDLE) && !q_empty;
    res_valid = (state == gsdt_pkg::ST_OUT);
  end

  assign step_total  = steps;
  assign distance_mm = dist_total;
  assign step_done   = w.done;
  assign in_step     = w.in_step;

  always_ff @(posedge clk) begin
    if (rst) state <= gsdt_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      steps      <= '0;
      dist_total <= '0;
    end else begin
      case (state)
        gsdt_pkg::ST_IDLE: begin
          if (!q_empty) begin
            w <= q_data;
            velocity_mm_s <= '0;
            if (q_data.done && steps != 16'hFFFF) steps <= steps + 16'd1;
          end
        end
        gsdt_pkg::ST_MUL1: begin
          acc <= {24'd0, 40'(w.mag) * 40'(w.dur)};
        end
        gsdt_pkg::ST_MUL2: begin
          // mag*T fits in 40 bits; times 23-bit constant stays below 64 bits.
          acc  <= 64'(acc[39:0] * 63'(gsdt_pkg::ANGLE_K));
          dvsr <= {24'd0, w.count};
          rem  <= '0;
          bitn <= '0;
        end
        gsdt_pkg::ST_DIV, gsdt_pkg::ST_VDIV: begin
          rem  <= sub[33] ? rem_sh[31:0] : sub[31:0];
          quo  <= (state == gsdt_pkg::ST_DIV && bitn == 6'd63 && w.count == 8'd0) ?
                  '0 : qnext;
          acc  <= {acc[62:0], 1'b0};
          bitn <= bitn + 6'd1;
          if (state == gsdt_pkg::ST_VDIV && bitn == 6'd63) begin
            velocity_mm_s <= (w.dur == 16'd0) ? 21'd0
                           : ((qnext > 64'h1F_FFFF) ? 21'h1F_FFFF : qnext[20:0]);
          end
        end
        gsdt_pkg::ST_FOLD: begin
          u <= 31'((64'(h32) * 64'(gsdt_pkg::TWO_PI_Q16)) >> 18);
        end
        gsdt_pkg::ST_USQ: begin
          u2     <= 32'((62'(u) * 62'(u)) >> 30);
          t      <= gsdt_pkg::ONE_Q30;
          hstage <= '0;
        end
        gsdt_pkg::ST_HORN_MUL: begin
          hp <= 32'((62'(u2) * 62'(t)) >> 30);
        end
        gsdt_pkg::ST_HORN_REC: begin
          hq <= 32'(hprod >> hs);
        end
        gsdt_pkg::ST_HORN_DIV: begin
          // Each stage is clamped at zero; it never exceeds one.
          t <= (hquo > {1'b0, gsdt_pkg::ONE_Q30}) ? 31'd0
             : 31'({1'b0, gsdt_pkg::ONE_Q30} - hquo);
          hstage <= hstage + 3'd1;
        end
        gsdt_pkg::ST_DIST: begin
          d <= 12'((42'(w.leg) * 42'(t) + 42'h2000_0000) >> 30);
        end
        gsdt_pkg::ST_VSET: begin
          // Rounded velocity dividend; a zero-duration step adds no distance.
          acc  <= {42'd0, 22'({10'd0, d} * 22'd1000)} + {49'd0, w.dur[15:1]};
          dvsr <= {16'd0, w.dur};
          rem  <= '0;
          bitn <= '0;
          if (w.dur != 16'd0) dist_total <= dsum[32] ? 32'hFFFF_FFFF : dsum[31:0];
        end
        default: ;
      endcase
    end
  end

endmodule

[rtl/gyro_step_distance_tracker.sv]
// ----------------------------------------------------------------------------
// gyro_step_distance_tracker: step counter and distance estimator
// Top level: classifier, work queue and step close engine.
// ----------------------------------------------------------------------------
// A sample is classified in the cycle it is pushed and queued. A sample that
// closes no step passes the engine's idle and output states, and the engine
// takes the next sample only after that result is popped. A step close runs
// a fixed sequence: a radix-2 phase division, five Horner stages, each a
// product, a reciprocal multiplication and a fix-up, and a radix-2 velocity
// division. Up to four samples wait in the queue while a close runs.
module gyro_step_distance_tracker (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               push,
  output logic               full,
  input  logic signed [15:0] rate_sample,
  input  logic [9:0]         elapsed_ms,
  output logic               empty,
  input  logic               pop,
  output logic               step_done,
  output logic [15:0]        step_total,
  output logic [31:0]        distance_mm,
  output logic [20:0]        velocity_mm_s,
  output logic               in_step
);

  gsdt_pkg::work_t fw, qw;
  logic q_empty, q_pop, res_valid;

  gsdt_front u_front (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .take(push && !full), .rate_sample, .elapsed_ms, .work(fw)
  );

  gsdt_queue u_queue (
    .clk, .rst, .wr(push), .wdata(fw), .full,
    .rd(q_pop), .empty(q_empty), .rdata(qw)
  );

  gsdt_back u_back (
    .clk, .rst, .q_empty, .q_data(qw), .q_pop, .res_valid, .res_pop(pop),
    .step_done, .step_total, .distance_mm, .velocity_mm_s, .in_step
  );

  assign empty = !res_valid;

endmodule

[tb/gyro_step_distance_tracker_tb.sv]
// ----------------------------------------------------------------------------
// gyro_step_distance_tracker_tb: self-checking bench of the step tracker
// A driver feeds gyro samples from a queue, a monitor checks each result
// against a cycle-free model of step detection, swing angle, |cos|,
// distance and velocity, and the run walks through several register settings with
// random idling on both sides.
// ----------------------------------------------------------------------------
module gyro_step_distance_tracker_tb;

  localparam int          CYCLE_LIMIT = 1000000;
  localparam longint      Q30_ONE     = 64'sd1073741824;

  typedef struct {
    logic signed [15:0] rate;
    logic [9:0]         ms;
  } sample_t;

  typedef struct {
    bit        done;
    bit [15:0] total;
    bit [31:0] distance;
    bit [20:0] vel;
    bit        open;
  } step_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;
  logic               push = 1'b0;
  logic               full;
  logic signed [15:0] rate_sample = '0;
  logic [9:0]         elapsed_ms = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic               step_done;
  logic [15:0]        step_total;
  logic [31:0]        distance_mm;
  logic [20:0]        velocity_mm_s;
  logic               in_step;

  gyro_step_distance_tracker dut (.*);

  always #10 clk = ~clk;

  // Model registers and state.
  int          m_rest_low, m_rest_high, m_start_thr;
  int unsigned m_leg;
  bit          m_open;
  int          m_sum;
  int unsigned m_count, m_dur, m_steps;
  longint unsigned m_dist;

  sample_t      pending_samples[$];
  step_result_t expected_results[$];
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  recv_hold = 1'b0;
  int  phase_no = 0;
  int  mismatches = 0;
  int  cycles = 0;

  // |cos| in Q30 of a phase given in 2^-48 turn.
  function automatic longint abs_cos(longint unsigned ph);
    longint unsigned g, h;
    longint u, u2, t;
    int div[5] = '{90, 56, 30, 12, 2};
    g = ph & 64'h7FFF_FFFF_FFFF;
    h = (g > 64'h4000_0000_0000) ? (64'h8000_0000_0000 - g) : g;
    u = longint'(((h >> 16) * 64'd411775) >> 18);
    u2 = (u * u) >>> 30;
    t = Q30_ONE;
    foreach (div[i]) begin
      t = Q30_ONE - ((u2 * t) >>> 30) / div[i];
      if (t < 0) t = 0;
      if (t > Q30_ONE) t = Q30_ONE;
    end
    return t;
  endfunction

  // Advance the step state by one sample and queue the result it gives.
  function automatic void track_sample(sample_t smp);
    step_result_t r;
    int s;
    longint unsigned mag, ph, d, v, t;
    s = smp.rate;
    r = '{default: 0};
    if (m_open) begin
      if (m_count < gsdt_pkg::MAX_SAMPLES) begin
        m_sum += s;
        m_count++;
      end
      m_dur += smp.ms;
      if (m_dur > 16'hFFFF) m_dur = 16'hFFFF;
    end
    if (m_open && s > m_rest_low && s < m_rest_high) begin
      r.done = 1'b1;
      if (m_steps < 16'hFFFF) m_steps++;
      t = m_dur;
      mag = (m_sum < 0) ? -m_sum : m_sum;
      ph = 0;
      if (m_count != 0) ph = ((mag * t * 64'd6859714) / m_count) & 64'hFFFF_FFFF_FFFF;
      if (t > 0) begin
        d = (longint'(m_leg) * abs_cos(ph) + 64'd536870912) >> 30;
        v = (d * 1000 + t / 2) / t;
        m_dist = m_dist + d;
        if (m_dist > 64'hFFFF_FFFF) m_dist = 64'hFFFF_FFFF;
        r.vel = (v > 64'h1F_FFFF) ? 21'h1F_FFFF : v[20:0];
      end
      m_open = 1'b0;
      m_sum = 0; m_count = 0; m_dur = 0;
    end
    if (s > m_start_thr && !m_open) begin
      m_open = 1'b1;
      m_sum = 0; m_count = 0; m_dur = 0;
    end
    r.total = m_steps[15:0];
    r.distance = m_dist[31:0];
    r.open = m_open;
    expected_results.push_back(r);
  endfunction

  task automatic flag_mismatch(string field, longint got, longint want);
    $display("mismatch on %s at %0d: got %0d, expected %0d", field, cycles, got, want);
    mismatches++;
  endtask

  // Driver: record each transfer, then offer the next pending sample.
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) track_sample(pending_samples.pop_front());
      if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        push <= 1'b1;
        rate_sample <= pending_samples[0].rate;
        elapsed_ms <= pending_samples[0].ms;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Monitor: check each result transfer against the oldest expectation.
  always @(posedge clk) begin
    step_result_t e;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          flag_mismatch("unexpected result", 1, 0);
        end else begin
          e = expected_results.pop_front();
          if (step_done !== e.done) flag_mismatch("step_done", step_done, e.done);
          if (step_total !== e.total) flag_mismatch("step_total", step_total, e.total);
          if (distance_mm !== e.distance)
            flag_mismatch("distance_mm", distance_mm, e.distance);
          if (velocity_mm_s !== e.vel) flag_mismatch("velocity_mm_s", velocity_mm_s, e.vel);
          if (in_step !== e.open) flag_mismatch("in_step", in_step, e.open);
        end
      end
      pop <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Long receiver hold-off in the third phase so the input queue fills.
  initial begin
    wait (phase_no == 2);
    repeat (50) @(posedge clk);
    recv_hold = 1'b1;
    repeat (3000) @(posedge clk);
    recv_hold = 1'b0;
  end

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      gsdt_pkg::REG_REST_LOW:   m_rest_low = $signed(data);
      gsdt_pkg::REG_REST_HIGH:  m_rest_high = $signed(data);
      gsdt_pkg::REG_START_THR:  m_start_thr = $signed(data);
      gsdt_pkg::REG_LEG_LENGTH: m_leg = data[10:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_sample(int rate, int ms);
    sample_t x;
    x.rate = 16'(rate);
    x.ms = 10'(ms);
    pending_samples.push_back(x);
  endtask

  function automatic int any_rate();
    return int'($signed(16'($urandom)));
  endfunction

  function automatic int any_ms();
    return ($urandom_range(3) == 0) ? $urandom_range(1023) : $urandom_range(40);
  endfunction

  // Sample that opens a step under the current threshold, when one exists.
  function automatic int opening_rate();
    if (m_start_thr >= 32767) return any_rate();
    return m_start_thr + 1 + int'($urandom_range(32766 - m_start_thr));
  endfunction

  // Sample strictly inside the rest band, when the band is not empty.
  function automatic int resting_rate();
    if (m_rest_high - m_rest_low < 2) return any_rate();
    return m_rest_low + 1 + int'($urandom_range(m_rest_high - m_rest_low - 2));
  endfunction

  // Mostly whole steps with random content, the rest noise.
  task automatic queue_random(int n);
    int made, len;
    made = 0;
    while (made < n) begin
      if ($urandom_range(9) < 7) begin
        len = ($urandom_range(49) == 0) ? 130 + $urandom_range(10) : $urandom_range(6);
        add_sample(opening_rate(), any_ms());
        repeat (len) add_sample(any_rate(), (len > 100) ? 1023 : any_ms());
        add_sample(resting_rate(), any_ms());
        made += len + 2;
      end else begin
        add_sample(any_rate(), any_ms());
        made++;
      end
    end
  endtask

  task automatic wait_drained();
    wait (pending_samples.size() == 0 && expected_results.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  // Stimulus: directed samples under reset settings, then random phases.
  initial begin
    static int cfg_set[5][4] = '{
      '{-100, 100, 2000, 920},
      '{-32768, 32767, -32768, 2047},
      '{-2000, 3000, 1000, 0},
      '{-300, 300, 32767, 1500},
      '{-30, 30, 500, 1200}
    };
    static int idle_set[5][2] = '{'{0, 0}, '{60, 0}, '{0, 60}, '{26, 26}, '{0, 0}};
    m_open = 0; m_sum = 0; m_count = 0; m_dur = 0; m_steps = 0; m_dist = 0;
    m_rest_low = -100; m_rest_high = 100; m_start_thr = 2000; m_leg = 920;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    foreach (cfg_set[p]) begin
      phase_no = p;
      if (p > 0) wait_drained();
      write_reg(gsdt_pkg::REG_REST_LOW, 16'(cfg_set[p][0]));
      write_reg(gsdt_pkg::REG_REST_HIGH, 16'(cfg_set[p][1]));
      write_reg(gsdt_pkg::REG_START_THR, 16'(cfg_set[p][2]));
      write_reg(gsdt_pkg::REG_LEG_LENGTH, 16'(cfg_set[p][3]));
      send_idle_pct = idle_set[p][0];
      recv_stall_pct = idle_set[p][1];
      if (p == 0) begin
        // Zero-duration step, band edges, start rates while open, extremes.
        add_sample(2001, 0);  add_sample(0, 0);
        add_sample(32767, 5); add_sample(-32768, 1023); add_sample(32767, 7);
        add_sample(-100, 3);  add_sample(100, 1023);   add_sample(-99, 12);
        add_sample(2000, 9);  add_sample(99, 4);
        add_sample(5000, 1);  add_sample(-32768, 1023); add_sample(1, 1);
        add_sample(3000, 0);  add_sample(20000, 1);    add_sample(0, 682);
      end
      queue_random(110);
    end
    wait_drained();
    repeat (500) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[gyro_step_distance_tracker.f]
rtl/gsdt_pkg.sv
rtl/gsdt_front.sv
rtl/gsdt_queue.sv
rtl/gsdt_back.sv
rtl/gyro_step_distance_tracker.sv
tb/gyro_step_distance_tracker_tb.sv
